// File: rtl/pip_pkg.sv
`default_nettype none

package pip_pkg;

   localparam int MAX_VERTICES_DEF = 16;
   localparam int COORD_BITS_DEF   = 16;
   localparam int VCOUNT_BITS      = 5;
   localparam int INDEX_BITS       = 4;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef struct packed {
      logic wr_en;
      logic load_point;
      logic rd_en;
      logic rd_edge;
      logic load_rsp;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/pip_ctrl.sv
`default_nettype none

module pip_ctrl #(
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_action,
   output logic                                  req_ready,
   input  wire logic                             csr_wr_en,
   input  wire logic [pip_pkg::VCOUNT_BITS-1:0]  csr_wr_data,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_valid,
   input  wire logic                             pipe_busy,
   output pip_pkg::cmd_type                      cmd,
   output logic [$clog2(MAX_VERTICES)-1:0]       rd_addr
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PRIME  = 5'b00010,
      ST_WALK   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type                        state_ff, state_in;
   logic [pip_pkg::VCOUNT_BITS-1:0]  vcount_ff, vcount_in;
   logic [CW-1:0]                    n_ff, n_in;
   logic [AW-1:0]                    idx_ff, idx_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                    n_sat;
   logic [CW-1:0]                    last;
   logic                             accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid & req_ready;
   assign last      = n_ff - CW'(1);

   always_comb begin
      n_sat = (int'(vcount_ff) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcount_ff);
   end

   always_comb begin
      cmd.wr_en      = accept & (req_action == pip_pkg::ACTION_WRITE);
      cmd.load_point = accept & (req_action == pip_pkg::ACTION_QUERY);
      cmd.rd_en      = (state_ff == ST_PRIME) | (state_ff == ST_WALK);
      cmd.rd_edge    = (state_ff == ST_WALK);
      cmd.load_rsp   = (state_ff == ST_FINISH) & (~rsp_valid_ff | rsp_ready);
      rd_addr        = (state_ff == ST_PRIME) ? last[AW-1:0] : idx_ff;
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      vcount_in    = csr_wr_en ? csr_wr_data : vcount_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load_point) begin
               n_in   = n_sat;
               idx_in = '0;
               if (n_sat == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (CW'(idx_ff) == last) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (cmd.load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= '0;
         n_ff         <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         n_ff         <= n_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pip_datapath.sv
`default_nettype none

module pip_datapath #(
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire pip_pkg::cmd_type                     cmd,
   input  wire logic [$clog2(MAX_VERTICES)-1:0]      rd_addr,
   input  wire logic [pip_pkg::INDEX_BITS-1:0]       vertex_index,
   input  wire logic signed [COORD_BITS-1:0]         coord_x,
   input  wire logic signed [COORD_BITS-1:0]         coord_y,
   output logic                                      pipe_busy,
   output logic                                      inside_res
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int IW = (AW > pip_pkg::INDEX_BITS) ? AW : pip_pkg::INDEX_BITS;
   localparam int D  = COORD_BITS + 1;
   localparam int P  = 2 * D;

   logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];

   logic [IW-1:0]                wr_idx_wide;
   logic [AW-1:0]                wr_addr;
   logic                         wr_in_range;

   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic signed [COORD_BITS-1:0] rd_x_ff, rd_y_ff;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff;
   logic                         rd_vld_ff, rd_edge_ff;

   logic                         a_vld_ff, a_vld_in;
   logic signed [D-1:0]          a_dxp_ff, a_dxe_ff, a_dy_ff, a_dpy_ff;

   logic                         b_vld_ff;
   logic signed [D-1:0]          b_dxp_ff, b_dxe_ff, b_ady_ff, b_ry_ff;

   logic                         c_vld_ff;
   logic signed [P-1:0]          c_lhs_ff, c_rhs_ff;

   logic                         parity_ff, parity_in;
   logic                         res_ff;
   logic                         straddle;

   assign wr_idx_wide = IW'(vertex_index);
   assign wr_addr     = wr_idx_wide[AW-1:0];
   assign wr_in_range = int'(vertex_index) < MAX_VERTICES;

   assign straddle  = (rd_y_ff > py_ff) != (prev_y_ff > py_ff);
   assign a_vld_in  = rd_vld_ff & rd_edge_ff & straddle;
   assign pipe_busy = rd_vld_ff | a_vld_ff | b_vld_ff | c_vld_ff;
   assign inside_res = res_ff;

   always_comb begin
      parity_in = parity_ff;
      if (cmd.load_point) begin
         parity_in = 1'b0;
      end else if (c_vld_ff && (c_lhs_ff < c_rhs_ff)) begin
         parity_in = ~parity_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_in_range) begin
         mem_x[wr_addr] <= coord_x;
         mem_y[wr_addr] <= coord_y;
      end
      if (cmd.rd_en) begin
         rd_x_ff <= mem_x[rd_addr];
         rd_y_ff <= mem_y[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         rd_edge_ff <= 1'b0;
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         parity_ff  <= 1'b0;
      end else begin
         rd_vld_ff  <= cmd.rd_en;
         rd_edge_ff <= cmd.rd_edge;
         a_vld_ff   <= a_vld_in;
         b_vld_ff   <= a_vld_ff;
         c_vld_ff   <= b_vld_ff;
         parity_ff  <= parity_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_point) begin
         px_ff <= coord_x;
         py_ff <= coord_y;
      end
      if (rd_vld_ff) begin
         prev_x_ff <= rd_x_ff;
         prev_y_ff <= rd_y_ff;
      end
      a_dxp_ff <= D'(px_ff) - D'(rd_x_ff);
      a_dxe_ff <= D'(prev_x_ff) - D'(rd_x_ff);
      a_dy_ff  <= D'(prev_y_ff) - D'(rd_y_ff);
      a_dpy_ff <= D'(py_ff) - D'(rd_y_ff);
      b_dxp_ff <= a_dxp_ff;
      b_dxe_ff <= a_dxe_ff;
      b_ady_ff <= a_dy_ff[D-1] ? -a_dy_ff : a_dy_ff;
      b_ry_ff  <= a_dy_ff[D-1] ? -a_dpy_ff : a_dpy_ff;
      c_lhs_ff <= P'(b_dxp_ff) * P'(b_ady_ff);
      c_rhs_ff <= P'(b_dxe_ff) * P'(b_ry_ff);
      if (cmd.load_rsp) begin
         res_ff <= parity_ff;
      end
   end

endmodule

`default_nettype wire

// File: rtl/point_in_polygon_test_unit.sv
// Vertex write: the block stays idle and is ready again in the next cycle.
// Query over n vertices in use: one edge per cycle through the single table read port;
// the result then waits for the edge pipeline to drain, which takes longer when a straddling
// edge is still in the later pipeline stages. Empty polygon: no table read. A stalled earlier result
// adds its wait. One query in flight; the next item is taken once the result is loaded.
// Synchronous active-high reset clears control state and vertex_count; tables undefined.
`default_nettype none

module point_in_polygon_test_unit #(
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_action,
   input  wire logic [pip_pkg::INDEX_BITS-1:0]      req_vertex_index,
   input  wire logic signed [COORD_BITS-1:0]        req_coord_x,
   input  wire logic signed [COORD_BITS-1:0]        req_coord_y,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_inside_res,
   input  wire logic                                csr_wr_en,
   input  wire logic [pip_pkg::VCOUNT_BITS-1:0]     csr_wr_data
);

   pip_pkg::cmd_type                  cmd;
   logic [$clog2(MAX_VERTICES)-1:0]   rd_addr;
   logic                              pipe_busy;

   pip_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_action  (req_action),
      .req_ready   (req_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .pipe_busy   (pipe_busy),
      .cmd         (cmd),
      .rd_addr     (rd_addr)
   );

   pip_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .rd_addr      (rd_addr),
      .vertex_index (req_vertex_index),
      .coord_x      (req_coord_x),
      .coord_y      (req_coord_y),
      .pipe_busy    (pipe_busy),
      .inside_res   (rsp_inside_res)
   );

endmodule

`default_nettype wire

// File: rtl/pip_checker.sv
`default_nettype none

module pip_props (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                req_action,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic                                rsp_inside_res
);

   logic req_xfer;

   assign req_xfer = req_valid & req_ready;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inside_res))
      else $error("stalled result changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset left result or busy pending");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_action == pip_pkg::ACTION_QUERY) |=> !req_ready)
      else $error("query transfer did not occupy the block");

   a_write_ready: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_action == pip_pkg::ACTION_WRITE) |=> req_ready)
      else $error("vertex write stalled the input");

endmodule

bind point_in_polygon_test_unit pip_props u_pip_props (.*);

`default_nettype wire
